// ----- rtl/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the chunked body decoder: field widths,
// status codes, register indexes and the per-byte result record.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	// length fields, size accumulator and frame limit
	localparam int LEN_W = 24;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_OVERRANGE = 2'd2,
		ST_NO_BODY   = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_FRAME_LIMIT  = 1'b0,
		REG_CHUNKED_MODE = 1'b1
	} reg_index_t;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	typedef struct packed {
		logic             valid;
		logic             kind;
		logic [7:0]       payload_byte;
		logic             last_payload;
		status_t          status;
		logic [LEN_W-1:0] chunk_length;
		logic [LEN_W-1:0] frame_length;
	} res_t;

endpackage

// ----- rtl/hcbd_parser.sv -----
// ----------------------------------------------------------------------------
// hcbd_parser
// Chunk framing state machine: size line, payload, trailer. Works out the
// result of the presented byte in one pass and advances on each step.
// ----------------------------------------------------------------------------
module hcbd_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       action,
	input  logic [7:0]                 byte_value,
	input  logic [hcbd_pkg::LEN_W-1:0] frame_limit,
	input  logic                       chunked_mode,
	output hcbd_pkg::res_t             res
);
	import hcbd_pkg::*;

	typedef enum logic [2:0] {
		PH_LINE    = 3'd0,
		PH_PAYLOAD = 3'd1,
		PH_TR_CR   = 3'd2,
		PH_TR_LF   = 3'd3,
		PH_HALT    = 3'd4
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] line_count_q, line_count_d;
	logic [LEN_W-1:0] size_accum_q, size_accum_d;
	logic [LEN_W-1:0] payload_left_q, payload_left_d;
	logic             size_overflow_q, size_overflow_d;
	logic             bad_char_q, bad_char_d;
	logic             prev_cr_q, prev_cr_d;

	logic [LEN_W-1:0] line_inc;
	logic [LEN_W+1:0] line_frame;
	logic [LEN_W+1:0] done_frame;
	logic [4:0]       hex;

	// bit 4 marks a hex digit, bits 3:0 its value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= "0" && c <= "9")
			r = {1'b1, 4'(c - "0")};
		else if (c >= "a" && c <= "f")
			r = {1'b1, 4'(c - "a" + 8'd10)};
		else if (c >= "A" && c <= "F")
			r = {1'b1, 4'(c - "A" + 8'd10)};
		return r;
	endfunction

	assign line_inc   = line_count_q + 1'b1;
	assign line_frame = {2'b00, line_inc} + {2'b00, size_accum_q} + (LEN_W+2)'(2);
	assign done_frame = {2'b00, line_count_q} + {2'b00, size_accum_q} + (LEN_W+2)'(2);
	assign hex        = hex_digit(byte_value);

	always_comb begin
		phase_d         = phase_q;
		line_count_d    = line_count_q;
		size_accum_d    = size_accum_q;
		payload_left_d  = payload_left_q;
		size_overflow_d = size_overflow_q;
		bad_char_d      = bad_char_q;
		prev_cr_d       = prev_cr_q;
		res             = '0;

		if (action == ACT_RESTART) begin
			phase_d         = PH_LINE;
			line_count_d    = '0;
			size_accum_d    = '0;
			payload_left_d  = '0;
			size_overflow_d = 1'b0;
			bad_char_d      = 1'b0;
			prev_cr_d       = 1'b0;
		end else if (!chunked_mode) begin
			res.valid  = 1'b1;
			res.kind   = KIND_STATUS;
			res.status = ST_NO_BODY;
		end else begin
			case (phase_q)
				PH_LINE: begin
					line_count_d = line_inc;
					if (prev_cr_q && byte_value == CH_LF) begin
						prev_cr_d = 1'b0;
						if (bad_char_q || size_overflow_q
						    || line_frame > {2'b00, frame_limit}) begin
							phase_d    = PH_HALT;
							res.valid  = 1'b1;
							res.kind   = KIND_STATUS;
							res.status = bad_char_q ? ST_INVALID : ST_OVERRANGE;
						end else begin
							payload_left_d = size_accum_q;
							phase_d = (size_accum_q != '0) ? PH_PAYLOAD : PH_TR_CR;
						end
					end else begin
						// a CR not followed by LF spoils the line
						if (prev_cr_q)
							bad_char_d = 1'b1;
						if (byte_value == CH_CR) begin
							prev_cr_d = 1'b1;
						end else begin
							prev_cr_d = 1'b0;
							if (!hex[4]) begin
								bad_char_d = 1'b1;
							end else if (!size_overflow_q) begin
								// saturate: any digit beyond the top nibble overflows
								if (size_accum_q[LEN_W-1 -: 4] != 4'd0)
									size_overflow_d = 1'b1;
								else
									size_accum_d = {size_accum_q[LEN_W-5:0], hex[3:0]};
							end
						end
						if (line_inc >= frame_limit) begin
							phase_d    = PH_HALT;
							res.valid  = 1'b1;
							res.kind   = KIND_STATUS;
							res.status = ST_OVERRANGE;
						end
					end
				end
				PH_PAYLOAD: begin
					res.valid        = 1'b1;
					res.kind         = KIND_PAYLOAD;
					res.payload_byte = byte_value;
					res.last_payload = (payload_left_q == LEN_W'(1));
					payload_left_d   = payload_left_q - 1'b1;
					if (payload_left_q == LEN_W'(1))
						phase_d = PH_TR_CR;
				end
				PH_TR_CR: begin
					bad_char_d = (byte_value != CH_CR);
					phase_d    = PH_TR_LF;
				end
				PH_TR_LF: begin
					res.valid = 1'b1;
					res.kind  = KIND_STATUS;
					if (bad_char_q || byte_value != CH_LF) begin
						phase_d    = PH_HALT;
						res.status = ST_INVALID;
					end else begin
						res.status       = ST_OK;
						res.chunk_length = size_accum_q;
						res.frame_length = done_frame[LEN_W-1:0];
						phase_d          = PH_LINE;
						line_count_d     = '0;
						size_accum_d     = '0;
						payload_left_d   = '0;
						size_overflow_d  = 1'b0;
						bad_char_d       = 1'b0;
						prev_cr_d        = 1'b0;
					end
				end
				default: begin
					// halted: swallow bytes until restart
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_LINE;
			line_count_q    <= '0;
			size_accum_q    <= '0;
			payload_left_q  <= '0;
			size_overflow_q <= 1'b0;
			bad_char_q      <= 1'b0;
			prev_cr_q       <= 1'b0;
		end else if (step) begin
			phase_q         <= phase_d;
			line_count_q    <= line_count_d;
			size_accum_q    <= size_accum_d;
			payload_left_q  <= payload_left_d;
			size_overflow_q <= size_overflow_d;
			bad_char_q      <= bad_char_d;
			prev_cr_q       <= prev_cr_d;
		end
	end

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> payload_left_q != '0)
		else $error("payload phase with nothing left to pass");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && action == ACT_RESTART
		|=> phase_q == PH_LINE && line_count_q == '0 && !prev_cr_q)
		else $error("restart did not return to size line start");

endmodule

// ----- rtl/http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Chunked transfer body decoder: parses hex size lines, passes payload bytes
// and reports one status per chunk frame.
// ----------------------------------------------------------------------------
// Takes one transaction per clock: each byte (or restart) is decoded in the
// cycle it is accepted and its result, if any, lands in the output register
// on the next edge. in_ready stays high unless that register holds a result
// that out_ready is not taking, so a stalled sink stops input after one
// result and throughput is one byte per cycle otherwise. The longest path is
// the size-line frame size check, a 26-bit add and compare against frame_limit.
// Errors halt the decoder until a restart transaction. Configuration writes
// take effect on the next edge and are meant for idle periods.
module http_chunked_body_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [hcbd_pkg::LEN_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       action,
	input  logic [7:0]                 byte_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       kind,
	output logic [7:0]                 payload_byte,
	output logic                       last_payload,
	output logic [1:0]                 status,
	output logic [hcbd_pkg::LEN_W-1:0] chunk_length,
	output logic [hcbd_pkg::LEN_W-1:0] frame_length
);
	import hcbd_pkg::*;

	logic [LEN_W-1:0] frame_limit_q;
	logic             chunked_mode_q;
	logic             out_valid_q;
	res_t             res;
	res_t             res_q;
	logic             accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q  <= LEN_W'(65536);
			chunked_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_FRAME_LIMIT:  frame_limit_q  <= cfg_data;
				REG_CHUNKED_MODE: chunked_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	hcbd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (accept),
		.action       (action),
		.byte_value   (byte_value),
		.frame_limit  (frame_limit_q),
		.chunked_mode (chunked_mode_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= res.valid;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// hold the result while the sink stalls
	always_ff @(posedge clk) begin
		if (accept && res.valid)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign payload_byte = res_q.payload_byte;
	assign last_payload = res_q.last_payload;
	assign status       = res_q.status;
	assign chunk_length = res_q.chunk_length;
	assign frame_length = res_q.frame_length;

	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == KIND_PAYLOAD
		|-> res_q.status == ST_OK && res_q.chunk_length == '0 && res_q.frame_length == '0)
		else $error("payload transaction carries status fields");

	a_frame_covers_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == KIND_STATUS && res_q.status == ST_OK
		|-> {1'b0, res_q.frame_length} >= {1'b0, res_q.chunk_length} + (LEN_W+1)'(2))
		else $error("frame length shorter than chunk plus trailer");

endmodule

// ----- sim/tb_http_chunked_body_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// Self-checking bench for the chunked body decoder. A cycle-free decoder
// written here predicts every payload byte and chunk status from the
// transactions that are accepted. Directed frames cover the error paths, then
// random chunk frames and noise run under several frame limits, both modes
// and three patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;
	import hcbd_pkg::*;

	localparam int             RESET_CYCLES    = 10;
	localparam int             SETTLE_CYCLES   = 4;
	localparam int             WATCHDOG_CYCLES = 2000;
	localparam int             MAX_REPORTS     = 10;
	localparam int             MAX_PAYLOAD_RUN = 64;
	localparam logic [LEN_W-1:0] LIMIT_DEFAULT = 24'd65536;
	localparam logic [LEN_W-1:0] LIMIT_MAX     = 24'hFFFFFF;
	localparam logic [LEN_W-1:0] SIZE_MAX      = 24'hFFFFFF;

	typedef enum logic [2:0] {
		PH_LINE,
		PH_PAYLOAD,
		PH_TRAILER_CR,
		PH_TRAILER_LF,
		PH_HALTED
	} chunk_phase_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [0:0]       cfg_index;
	logic [LEN_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic             action;
	logic [7:0]       byte_value;
	logic             out_valid;
	logic             out_ready;
	logic             kind;
	logic [7:0]       payload_byte;
	logic             last_payload;
	logic [1:0]       status;
	logic [LEN_W-1:0] chunk_length;
	logic [LEN_W-1:0] frame_length;

	// decoder state and registers as the bench sees them
	chunk_phase_t     ph;
	logic [LEN_W-1:0] line_cnt;
	logic [LEN_W-1:0] size_acc;
	logic             size_ovf;
	logic             bad_seen;
	logic             cr_seen;
	logic [LEN_W-1:0] pay_left;
	logic [LEN_W-1:0] lim_frame;
	logic             mode_chunked;

	res_t decoded_records[$];
	int   mismatches;
	int   items_sent;
	int   idle_cycles;
	int   send_idle_pct;
	int   recv_stall_pct;

	http_chunked_body_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.byte_value   (byte_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.last_payload (last_payload),
		.status       (status),
		.chunk_length (chunk_length),
		.frame_length (frame_length)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic void restart_chunk();
		ph       = PH_LINE;
		line_cnt = '0;
		size_acc = '0;
		size_ovf = 1'b0;
		bad_seen = 1'b0;
		cr_seen  = 1'b0;
		pay_left = '0;
	endfunction

	function automatic void push_status(input status_t st, input logic [LEN_W-1:0] clen,
			input logic [LEN_W-1:0] flen);
		res_t rec;
		rec              = '0;
		rec.valid        = 1'b1;
		rec.kind         = KIND_STATUS;
		rec.status       = st;
		rec.chunk_length = clen;
		rec.frame_length = flen;
		decoded_records.push_back(rec);
	endfunction

	function automatic void halt_with(input status_t st);
		ph = PH_HALTED;
		push_status(st, '0, '0);
	endfunction

	// Advance the decoder by one accepted transaction and queue what it emits.
	function automatic void decode_transaction(input logic act, input logic [7:0] b);
		logic [LEN_W+1:0] frame_sum;
		logic [LEN_W+3:0] shifted;
		logic [LEN_W-1:0] clen;
		logic [LEN_W-1:0] flen;
		int               digit;
		res_t             rec;
		if (act == ACT_RESTART) begin
			restart_chunk();
			return;
		end
		if (!mode_chunked) begin
			push_status(ST_NO_BODY, '0, '0);
			return;
		end
		case (ph)
		PH_LINE: begin
			line_cnt = line_cnt + 1'b1;
			if (cr_seen && b == CH_LF) begin
				cr_seen   = 1'b0;
				frame_sum = line_cnt + size_acc + 26'd2;
				if (bad_seen) begin
					halt_with(ST_INVALID);
				end else if (size_ovf || frame_sum > lim_frame) begin
					halt_with(ST_OVERRANGE);
				end else begin
					pay_left = size_acc;
					if (size_acc != '0)
						ph = PH_PAYLOAD;
					else
						ph = PH_TRAILER_CR;
				end
				return;
			end
			// a CR must be followed by LF, anything else spoils the line
			if (cr_seen)
				bad_seen = 1'b1;
			if (b == CH_CR) begin
				cr_seen = 1'b1;
			end else begin
				cr_seen = 1'b0;
				digit   = -1;
				if (b >= "0" && b <= "9")
					digit = int'(b - "0");
				else if (b >= "a" && b <= "f")
					digit = b - "a" + 10;
				else if (b >= "A" && b <= "F")
					digit = b - "A" + 10;
				if (digit < 0) begin
					bad_seen = 1'b1;
				end else if (!size_ovf) begin
					// saturate rather than wrap
					shifted = {size_acc, digit[3:0]};
					if (shifted > SIZE_MAX)
						size_ovf = 1'b1;
					else
						size_acc = shifted[LEN_W-1:0];
				end
			end
			if (line_cnt >= lim_frame)
				halt_with(ST_OVERRANGE);
		end
		PH_PAYLOAD: begin
			rec              = '0;
			rec.valid        = 1'b1;
			rec.kind         = KIND_PAYLOAD;
			rec.payload_byte = b;
			rec.last_payload = (pay_left == 1);
			decoded_records.push_back(rec);
			if (pay_left != '0)
				pay_left = pay_left - 1'b1;
			if (pay_left == '0)
				ph = PH_TRAILER_CR;
		end
		PH_TRAILER_CR: begin
			bad_seen = (b != CH_CR);
			ph       = PH_TRAILER_LF;
		end
		PH_TRAILER_LF: begin
			clen = size_acc;
			flen = line_cnt + size_acc + 24'd2;
			if (bad_seen || b != CH_LF) begin
				halt_with(ST_INVALID);
			end else begin
				restart_chunk();
				push_status(ST_OK, clen, flen);
			end
		end
		default: ;
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10)
			return "0" + nib;
		return (($urandom_range(1) != 0) ? "A" : "a") + nib - 8'd10;
	endfunction

	// Offer one transaction, holding it until the decoder takes it.
	task automatic send_item(input logic act, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		byte_value <= b;
		do
			@(posedge clk);
		while (!in_ready);
		decode_transaction(act, b);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(ACT_BYTE, s[i]);
	endtask

	task automatic send_crlf();
		send_item(ACT_BYTE, CH_CR);
		send_item(ACT_BYTE, CH_LF);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (decoded_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [LEN_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_FRAME_LIMIT:  lim_frame = value;
		REG_CHUNKED_MODE: mode_chunked = value[0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	// One chunk frame with random content; a few carry a flaw in the size line
	// or trailer.
	task automatic send_chunk_frame();
		int unsigned      sz;
		int unsigned      flaw;
		int unsigned      n;
		logic [LEN_W-1:0] v;
		logic [7:0]       line[$];
		if (ph != PH_LINE || line_cnt != '0 || $urandom_range(19) == 0)
			send_item(ACT_RESTART, 8'($urandom));
		flaw = $urandom_range(99);
		sz   = ($urandom_range(7) == 0) ? $urandom_range(48) : $urandom_range(6);
		v    = LEN_W'(sz);
		if (flaw < 5) begin
			// size beyond the accumulator
			n = $urandom_range(9, 7);
			line.push_back(hex_char(4'($urandom_range(15, 1))));
			repeat (n - 1) line.push_back(hex_char(4'($urandom)));
		end else begin
			do begin
				line.push_front(hex_char(v[3:0]));
				v = v >> 4;
			end while (v != '0);
			if (sz == 0 && $urandom_range(3) == 0)
				line.delete();
			repeat (($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0)
				line.push_front("0");
		end
		if (flaw >= 5 && flaw < 9)
			line.insert($urandom_range(line.size()), 8'($urandom));
		else if (flaw >= 9 && flaw < 11)
			line.insert($urandom_range(line.size()), CH_CR);
		else if (flaw >= 11 && flaw < 13)
			line.insert($urandom_range(line.size()), CH_LF);
		foreach (line[i])
			send_item(ACT_BYTE, line[i]);
		send_crlf();
		if (ph == PH_HALTED)
			return;
		// a stray digit may have blown the size up: drop the frame
		if (pay_left > MAX_PAYLOAD_RUN) begin
			send_item(ACT_RESTART, 8'($urandom));
			return;
		end
		n = 32'(pay_left);
		repeat (n) send_item(ACT_BYTE, 8'($urandom));
		if (flaw >= 13 && flaw < 20) begin
			case ($urandom_range(2))
			0: begin
				send_item(ACT_BYTE, CH_CR);
				send_item(ACT_BYTE, 8'($urandom));
			end
			1: begin
				send_item(ACT_BYTE, 8'($urandom));
				send_item(ACT_BYTE, CH_LF);
			end
			default: begin
				send_item(ACT_BYTE, CH_LF);
				send_item(ACT_BYTE, CH_CR);
			end
			endcase
		end else begin
			send_crlf();
		end
	endtask

	task automatic send_noise();
		int unsigned pick;
		repeat ($urandom_range(12, 1)) begin
			pick = $urandom_range(99);
			if (pick < 30)
				send_item(ACT_BYTE, hex_char(4'($urandom)));
			else if (pick < 45)
				send_item(ACT_BYTE, CH_CR);
			else if (pick < 60)
				send_item(ACT_BYTE, CH_LF);
			else if (pick < 95)
				send_item(ACT_BYTE, 8'($urandom));
			else
				send_item(ACT_RESTART, 8'($urandom));
		end
	endtask

	task automatic run_traffic(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(99) < 80)
				send_chunk_frame();
			else
				send_noise();
		end
	endtask

	task automatic test_wellformed_frames();
		send_item(ACT_RESTART, 8'hFF);
		// empty size line: zero-length chunk
		send_crlf();
		send_crlf();
		send_text("1");
		send_crlf();
		send_item(ACT_BYTE, 8'hFF);
		send_crlf();
	endtask

	task automatic test_size_line_errors();
		// CR not followed by LF, then a non-hex byte
		send_item(ACT_BYTE, CH_CR);
		send_text("g");
		send_crlf();
		send_item(ACT_BYTE, 8'h00);
		send_item(ACT_RESTART, 8'h00);
		// LF without a CR in front
		send_item(ACT_BYTE, CH_LF);
		send_crlf();
		send_item(ACT_RESTART, 8'h5A);
	endtask

	task automatic test_trailer_errors();
		send_crlf();
		send_item(ACT_BYTE, CH_CR);
		send_text("x");
		send_item(ACT_RESTART, 8'h00);
	endtask

	task automatic test_no_body_mode();
		wait_idle();
		write_reg(REG_CHUNKED_MODE, 24'd0);
		send_text("A");
		wait_idle();
		write_reg(REG_CHUNKED_MODE, 24'd1);
	endtask

	task automatic test_frame_limit_edges();
		wait_idle();
		// line 3 + size 1 + trailer 2 overruns a limit of 5
		write_reg(REG_FRAME_LIMIT, 24'd5);
		send_text("1");
		send_crlf();
		send_item(ACT_RESTART, 8'h00);
		wait_idle();
		write_reg(REG_FRAME_LIMIT, LIMIT_DEFAULT);
	endtask

	task automatic test_random_traffic(input int src_idle, input int sink_stall);
		send_idle_pct  = src_idle;
		recv_stall_pct = sink_stall;
		wait_idle();
		write_reg(REG_FRAME_LIMIT, LIMIT_DEFAULT);
		write_reg(REG_CHUNKED_MODE, 24'd1);
		run_traffic(230);
		wait_idle();
		write_reg(REG_FRAME_LIMIT, 24'($urandom_range(40, 8)));
		run_traffic(150);
		wait_idle();
		write_reg(REG_CHUNKED_MODE, 24'd0);
		run_traffic(30);
		wait_idle();
		write_reg(REG_CHUNKED_MODE, 24'd1);
		write_reg(REG_FRAME_LIMIT, LIMIT_MAX);
		run_traffic(100);
		wait_idle();
		// limits of 0 and 1 stop every size line at its first byte
		write_reg(REG_FRAME_LIMIT, 24'($urandom_range(1)));
		run_traffic(20);
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (decoded_records.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%t: unexpected result kind %0d status %0d", $realtime,
						kind, status);
				mismatches++;
			end else begin
				want = decoded_records.pop_front();
				if (kind !== want.kind || payload_byte !== want.payload_byte ||
						last_payload !== want.last_payload || status !== want.status ||
						chunk_length !== want.chunk_length ||
						frame_length !== want.frame_length) begin
					if (mismatches < MAX_REPORTS) begin
						$write("%t: mismatch (expected/actual) kind %0d/%0d byte %02h/%02h",
							$realtime, want.kind, kind, want.payload_byte, payload_byte);
						$display(" last %0d/%0d status %0d/%0d chunk %0d/%0d frame %0d/%0d",
							want.last_payload, last_payload, want.status, status,
							want.chunk_length, chunk_length, want.frame_length,
							frame_length);
					end
					mismatches++;
				end
			end
		end
	end

	// End the run if neither side moves a transaction for too long.
	initial begin
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= REG_FRAME_LIMIT;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		action         <= ACT_BYTE;
		byte_value     <= 8'h00;
		mismatches     = 0;
		items_sent     = 0;
		send_idle_pct  = 25;
		recv_stall_pct = 83;
		lim_frame      = LIMIT_DEFAULT;
		mode_chunked   = 1'b1;
		restart_chunk();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_wellformed_frames();
		test_size_line_errors();
		test_trailer_errors();
		test_no_body_mode();
		test_frame_limit_edges();
		test_random_traffic(25, 83);
		test_random_traffic(83, 25);
		test_random_traffic(0, 0);

		wait_idle();
		if (mismatches == 0 && decoded_records.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/hcbd_pkg.sv
rtl/hcbd_parser.sv
rtl/http_chunked_body_decoder.sv
sim/tb_http_chunked_body_decoder.sv
